@@ hw/rtl/ultrasonic_range_min_of_sensors_assert.svh @@
// Assertion macros used by the checker file.
`ifndef ULTRASONIC_RANGE_MIN_OF_SENSORS_ASSERT_SVH
`define ULTRASONIC_RANGE_MIN_OF_SENSORS_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define URM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ranging controller check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define URM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ranging controller check failed");

`endif

@@ hw/rtl/urm_pkg.sv @@
`default_nettype none

package urm_pkg;

   // Field and register widths
   localparam int TIMER_W    = 16;
   localparam int SUM_W      = 19;
   localparam int DIST_W     = 16;
   localparam int ECHO_W     = 4;
   localparam int SAMPLE_W   = 3;
   localparam int DIVISOR_W  = 12;
   localparam int DIVIDEND_W = SUM_W + 3;
   localparam int DCNT_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_SENSORS_DEF = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_US = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSORS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_US_PER_CM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_US     = 3'd4;

   // Register reset values
   localparam logic [7:0]  RST_TRIGGER_US = 8'd20;
   localparam logic [3:0]  RST_SAMPLES    = 4'd5;
   localparam logic [2:0]  RST_SENSORS    = 3'd3;
   localparam logic [7:0]  RST_US_PER_CM  = 8'd58;
   localparam logic [15:0] RST_GAP_US     = 16'd30000;

   localparam logic [3:0] MAX_SAMPLES = 4'd8;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_TRIG = 5'b00010,
      PH_WAIT = 5'b00100,
      PH_ECHO = 5'b01000,
      PH_GAP  = 5'b10000
   } phase_type;

   // Micro-operations issued by the sequencer
   typedef enum logic [2:0] {
      UOP_FETCH  = 3'd0,
      UOP_EVAL   = 3'd1,
      UOP_DLOAD  = 3'd2,
      UOP_DSTEP  = 3'd3,
      UOP_FINISH = 3'd4,
      UOP_EMIT   = 3'd5
   } uop_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_ACCEPT   = 3'd1,
      COND_NEED_DIV = 3'd2,
      COND_DIV_LAST = 3'd3,
      COND_OUT_FREE = 3'd4
   } cond_sel_type;

   typedef struct packed {
      uop_type op;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic need_div;
      logic div_last;
      logic out_free;
   } flags_type;

   typedef struct packed {
      logic              start_req;
      logic [ECHO_W-1:0] echo_levels;
   } req_type;

   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] nearest_distance;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/urm_seq.sv @@
`default_nettype none

module urm_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire urm_pkg::flags_type flags,
   output urm_pkg::ctrl_type       ctrl
);
   import urm_pkg::*;

   localparam int UPC_W = 3;

   localparam logic [UPC_W-1:0] STEP_FETCH  = 3'd0;
   localparam logic [UPC_W-1:0] STEP_EVAL   = 3'd1;
   localparam logic [UPC_W-1:0] STEP_DLOAD  = 3'd2;
   localparam logic [UPC_W-1:0] STEP_DSTEP  = 3'd3;
   localparam logic [UPC_W-1:0] STEP_FINISH = 3'd4;
   localparam logic [UPC_W-1:0] STEP_EMIT   = 3'd5;

   typedef struct packed {
      uop_type          op;
      cond_sel_type     cond;
      logic [UPC_W-1:0] jump_t;
      logic [UPC_W-1:0] jump_f;
   } uword_type;

   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] step);
      uword_type w;
      begin
         case (step)
            STEP_FETCH:  w = '{UOP_FETCH,  COND_ACCEPT,   STEP_EVAL,   STEP_FETCH};
            STEP_EVAL:   w = '{UOP_EVAL,   COND_NEED_DIV, STEP_DLOAD,  STEP_EMIT};
            STEP_DLOAD:  w = '{UOP_DLOAD,  COND_ALWAYS,   STEP_DSTEP,  STEP_DSTEP};
            STEP_DSTEP:  w = '{UOP_DSTEP,  COND_DIV_LAST, STEP_FINISH, STEP_DSTEP};
            STEP_FINISH: w = '{UOP_FINISH, COND_ALWAYS,   STEP_EMIT,   STEP_EMIT};
            STEP_EMIT:   w = '{UOP_EMIT,   COND_OUT_FREE, STEP_FETCH,  STEP_EMIT};
            default:     w = '{UOP_FETCH,  COND_ALWAYS,   STEP_FETCH,  STEP_FETCH};
         endcase
         return w;
      end
   endfunction

   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        uword;
   logic             hit;

   always_comb begin
      uword = ucode_rom(upc_ff);
      case (uword.cond)
         COND_ALWAYS:   hit = 1'b1;
         COND_ACCEPT:   hit = flags.accept;
         COND_NEED_DIV: hit = flags.need_div;
         COND_DIV_LAST: hit = flags.div_last;
         COND_OUT_FREE: hit = flags.out_free;
         default:       hit = 1'b1;
      endcase
      upc_in  = hit ? uword.jump_t : uword.jump_f;
      ctrl.op = uword.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ultrasonic_range_min_of_sensors.sv @@
// Channel | Direction | Handshake           | Content
// req_    | in        | req_valid/req_stall | one microsecond tick: start_req, echo_levels
// rsp_    | out       | rsp_valid/rsp_stall | trigger, busy, done, nearest_distance
// csr_    | in        | csr_valid/csr_ready | register index and write data
//
// A tick passes through fetch, evaluate and emit, waiting in emit while the output stalls;
// a tick that closes a sensor adds load, the 22-step shift-subtract divider and finish.
// One tick is worked on at a time; the next one is taken while the last result waits.
// Reset is synchronous: registers return to defaults, phase goes idle.
// A stalled result is held in the output register until taken.
`default_nettype none

module ultrasonic_range_min_of_sensors #(
   parameter int MAX_SENSORS = urm_pkg::MAX_SENSORS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tick input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire urm_pkg::req_type                   req_data,
   // result output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output urm_pkg::rsp_type                        rsp_data,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [urm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [urm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import urm_pkg::*;

   localparam int SENS_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam logic [2:0] MAX_CNT = 3'(MAX_SENSORS);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0]  trigger_us_ff;
   logic [3:0]  samples_ff;
   logic [2:0]  sensors_ff;
   logic [7:0]  us_per_cm_ff;
   logic [15:0] gap_us_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_us_ff <= RST_TRIGGER_US;
         samples_ff    <= RST_SAMPLES;
         sensors_ff    <= RST_SENSORS;
         us_per_cm_ff  <= RST_US_PER_CM;
         gap_us_ff     <= RST_GAP_US;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIGGER_US: trigger_us_ff <= csr_wdata[7:0];
            CSR_SAMPLES:    samples_ff    <= csr_wdata[3:0];
            CSR_SENSORS:    sensors_ff    <= csr_wdata[2:0];
            CSR_US_PER_CM:  us_per_cm_ff  <= csr_wdata[7:0];
            CSR_GAP_US:     gap_us_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the loop limits to their legal ranges
   logic [3:0] eff_samples;
   logic [2:0] eff_sensors;

   always_comb begin
      if (samples_ff == 4'd0)             eff_samples = 4'd1;
      else if (samples_ff > MAX_SAMPLES)  eff_samples = MAX_SAMPLES;
      else                                eff_samples = samples_ff;

      if (sensors_ff == 3'd0)             eff_sensors = 3'd1;
      else if (sensors_ff > MAX_CNT)      eff_sensors = MAX_CNT;
      else                                eff_sensors = sensors_ff;
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   ctrl_type  ctrl;
   flags_type flags;

   urm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // Ticks are taken only while the program sits at its fetch step
   assign req_stall = (ctrl.op != UOP_FETCH);
   wire accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Datapath state
   // ---------------------------------------------------------------
   phase_type             phase_ff,   phase_in;
   logic [SENS_W-1:0]     sensor_ff,  sensor_in;
   logic [SAMPLE_W-1:0]   sample_ff,  sample_in;
   logic [TIMER_W-1:0]    timer_ff,   timer_in;
   logic [SUM_W-1:0]      sum_ff,     sum_in;
   logic [DIST_W-1:0]     best_ff,    best_in;
   logic                  done_ff,    done_in;

   // latched tick
   logic                  start_ff,   start_in;
   logic [ECHO_W-1:0]     echo_ff,    echo_in;

   // divider
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  rem_ff,     rem_in;
   logic [DIVIDEND_W-1:0] quo_ff,     quo_in;
   logic [DCNT_W-1:0]     dcnt_ff,    dcnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   logic                  need_div;
   logic                  level;
   logic [TIMER_W-1:0]    gap_next;
   logic                  advance;
   logic [DIVISOR_W:0]    trial;
   logic [DIST_W-1:0]     sensor_dist;
   logic                  out_free;

   assign level    = echo_ff[sensor_ff];
   assign gap_next = timer_ff + 16'd1;
   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A zero divisor makes every trial succeed: the quotient is all ones and saturates
   assign sensor_dist = (quo_ff[DIVIDEND_W-1:DIST_W] != '0) ? DIST_MAX : quo_ff[DIST_W-1:0];

   always_comb begin
      phase_in     = phase_ff;
      sensor_in    = sensor_ff;
      sample_in    = sample_ff;
      timer_in     = timer_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      done_in      = done_ff;
      start_in     = start_ff;
      echo_in      = echo_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      need_div     = 1'b0;
      advance      = 1'b0;

      case (ctrl.op)
         UOP_FETCH: begin
            // capture the tick
            if (accept) begin
               start_in = req_data.start_req;
               echo_in  = req_data.echo_levels;
            end
         end

         UOP_EVAL: begin
            done_in = 1'b0;
            case (phase_ff)
               PH_IDLE: begin
                  if (start_ff) begin
                     sensor_in = '0;
                     sample_in = '0;
                     sum_in    = '0;
                     best_in   = DIST_MAX;
                     phase_in  = PH_TRIG;
                     timer_in  = 16'd1;
                  end
               end
               PH_TRIG: begin
                  if (timer_ff >= {8'h00, trigger_us_ff}) begin
                     phase_in = PH_WAIT;
                     timer_in = '0;
                  end else begin
                     timer_in = timer_ff + 16'd1;
                  end
               end
               PH_WAIT: begin
                  if (level) begin
                     phase_in = PH_ECHO;
                     timer_in = 16'd1;
                  end
               end
               PH_ECHO: begin
                  if (level) begin
                     // saturate the echo width
                     if (timer_ff != '1) timer_in = timer_ff + 16'd1;
                  end else begin
                     sum_in   = sum_ff + SUM_W'(timer_ff);
                     timer_in = '0;
                     if (gap_us_ff == '0) advance  = 1'b1;
                     else                 phase_in = PH_GAP;
                  end
               end
               PH_GAP: begin
                  timer_in = gap_next;
                  if (gap_next >= gap_us_ff) advance = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
               end
            endcase

            // next sample of the same sensor, or hand off to the divider
            if (advance) begin
               if ((4'(sample_ff) + 4'd1) < eff_samples) begin
                  sample_in = sample_ff + 3'd1;
                  phase_in  = PH_TRIG;
                  timer_in  = 16'd1;
               end else begin
                  need_div = 1'b1;
               end
            end
         end

         UOP_DLOAD: begin
            divisor_in = DIVISOR_W'(us_per_cm_ff * eff_samples);
            quo_in     = {sum_ff, 3'b000};
            rem_in     = '0;
            dcnt_in    = '0;
         end

         UOP_DSTEP: begin
            // one quotient bit per cycle, restoring
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in = DIVISOR_W'(trial - {1'b0, divisor_ff});
               quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIVISOR_W-1:0];
               quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
         end

         UOP_FINISH: begin
            if (sensor_dist < best_ff) best_in = sensor_dist;
            sample_in = '0;
            sum_in    = '0;
            if ((3'(sensor_ff) + 3'd1) >= eff_sensors) begin
               // last sensor: end of run
               phase_in  = PH_IDLE;
               timer_in  = '0;
               sensor_in = '0;
               done_in   = 1'b1;
            end else begin
               sensor_in = sensor_ff + SENS_W'(1);
               phase_in  = PH_TRIG;
               timer_in  = 16'd1;
            end
         end

         UOP_EMIT: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.trigger_level    = (phase_ff == PH_TRIG);
               rsp_data_in.busy_res         = (phase_ff != PH_IDLE);
               rsp_data_in.done_res         = done_ff;
               rsp_data_in.nearest_distance = done_ff ? best_ff : '0;
            end
         end

         default: ;
      endcase
   end

   always_comb begin
      flags.accept   = accept;
      flags.need_div = need_div;
      flags.div_last = (dcnt_ff == 5'(DIVIDEND_W - 1));
      flags.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sensor_ff    <= '0;
         sample_ff    <= '0;
         timer_ff     <= '0;
         sum_ff       <= '0;
         best_ff      <= DIST_MAX;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sensor_ff    <= sensor_in;
         sample_ff    <= sample_in;
         timer_ff     <= timer_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      echo_ff     <= echo_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/urm_checker.sv @@
`default_nettype none
`include "ultrasonic_range_min_of_sensors_assert.svh"

module urm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire urm_pkg::rsp_type               rsp_data
);
   import urm_pkg::*;

   // a finished run reports idle
   `URM_ASSERT_NOW(a_done_not_busy, rsp_valid && rsp_data.done_res, !rsp_data.busy_res)
   // distance shows only with done
   `URM_ASSERT_NOW(a_dist_zero, rsp_valid && !rsp_data.done_res, rsp_data.nearest_distance == '0)
   // trigger is driven only inside a run
   `URM_ASSERT_NOW(a_trig_busy, rsp_valid && rsp_data.trigger_level, rsp_data.busy_res)
   // hold a stalled result
   `URM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind ultrasonic_range_min_of_sensors urm_checker u_urm_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import urm_pkg::*;

   localparam int unsigned SENSOR_COUNT = MAX_SENSORS_DEF;
   localparam int unsigned RANDOM_TICKS = 1000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   // worst case: every tick closing a sensor behind full stall and gap bursts
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   // leave margin at the end for a tick that closes a sensor
   localparam int unsigned SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted register contents, mirrored on every accepted write
   logic [7:0]  cfg_trigger = RST_TRIGGER_US;
   logic [3:0]  cfg_samples = RST_SAMPLES;
   logic [2:0]  cfg_sensors = RST_SENSORS;
   logic [7:0]  cfg_us_per_cm = RST_US_PER_CM;
   logic [15:0] cfg_gap = RST_GAP_US;

   // predicted controller state
   phase_type   m_phase = PH_IDLE;
   logic [1:0]  m_sensor = '0;
   logic [2:0]  m_sample = '0;
   logic [15:0] m_timer = '0;
   logic [18:0] m_sum = '0;
   logic [15:0] m_best = '1;

   req_type     tick_queue[$];
   rsp_type     expected_q[$];

   int unsigned ticks_queued = 0;
   int unsigned ticks_checked = 0;
   int unsigned runs_finished = 0;
   int unsigned csr_writes = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_odds = 0;
   int unsigned send_gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit          hold_request = 1'b0;

   always #5 clock = ~clock;

   ultrasonic_range_min_of_sensors #(
      .MAX_SENSORS(SENSOR_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------
   // Ranging predictor
   // ---------------------------------------------------------------

   // Zero samples count as one; anything above eight counts as eight.
   function automatic int unsigned samples_in_force();
      if (cfg_samples == 4'd0) return 1;
      if (cfg_samples > MAX_SAMPLES) return MAX_SAMPLES;
      return cfg_samples;
   endfunction

   // Zero sensors count as one; clamp to the sensors that exist.
   function automatic int unsigned sensors_in_force();
      if (cfg_sensors == 3'd0) return 1;
      if (cfg_sensors > SENSOR_COUNT) return SENSOR_COUNT;
      return cfg_sensors;
   endfunction

   // Close one echo measurement: move to the next sample, the next sensor,
   // or finish the run. Return 1 when the run has finished.
   function automatic bit close_echo();
      int unsigned divisor;
      int unsigned distance;
      if (m_sample + 1 < samples_in_force()) begin
         m_sample = m_sample + 1'b1;
      end else begin
         // averaged width in eighths of a cm; a zero divisor saturates
         divisor = cfg_us_per_cm * samples_in_force();
         if (divisor == 0) begin
            distance = 16'hFFFF;
         end else begin
            distance = (m_sum * 8) / divisor;
            if (distance > 16'hFFFF) distance = 16'hFFFF;
         end
         if (distance < m_best) m_best = 16'(distance);
         m_sample = '0;
         m_sum = '0;
         if (m_sensor + 1 >= sensors_in_force()) begin
            m_phase = PH_IDLE;
            m_timer = '0;
            m_sensor = '0;
            return 1'b1;
         end
         m_sensor = m_sensor + 1'b1;
      end
      m_phase = PH_TRIG;
      m_timer = 16'd1;
      return 1'b0;
   endfunction

   // Advance the predicted controller by one microsecond tick.
   function automatic rsp_type step_ranging(req_type t);
      rsp_type r;
      bit      level;
      bit      done;
      level = t.echo_levels[m_sensor];
      done = 1'b0;
      case (m_phase)
         PH_IDLE: begin
            if (t.start_req) begin
               m_sensor = '0;
               m_sample = '0;
               m_sum = '0;
               m_best = '1;
               m_phase = PH_TRIG;
               m_timer = 16'd1;
            end
         end
         PH_TRIG: begin
            if (m_timer >= cfg_trigger) begin
               m_phase = PH_WAIT;
               m_timer = '0;
            end else begin
               m_timer = m_timer + 1'b1;
            end
         end
         PH_WAIT: begin
            // no timeout: stay here until the echo rises
            if (level) begin
               m_phase = PH_ECHO;
               m_timer = 16'd1;
            end
         end
         PH_ECHO: begin
            if (level) begin
               if (m_timer != 16'hFFFF) m_timer = m_timer + 1'b1;
            end else begin
               m_sum = m_sum + m_timer;
               m_timer = '0;
               if (cfg_gap == 16'd0) done = close_echo();
               else m_phase = PH_GAP;
            end
         end
         PH_GAP: begin
            m_timer = m_timer + 1'b1;
            if (m_timer >= cfg_gap) done = close_echo();
         end
         default: begin
            m_phase = PH_IDLE;
            m_timer = '0;
         end
      endcase
      r = '0;
      r.trigger_level = (m_phase == PH_TRIG);
      r.busy_res = (m_phase != PH_IDLE);
      r.done_res = done;
      r.nearest_distance = done ? m_best : '0;
      return r;
   endfunction

   function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Tick driver: feed ticks from the queue, with random gap bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on every accepted transaction
         if (req_valid && !req_stall) begin
            expected_q.push_back(step_ranging(req_data));
         end
         // load the next tick only once the current one is gone; hold a stalled payload
         if (!req_valid || !req_stall) begin
            if (send_gap_left != 0) begin
               send_gap_left--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_data <= tick_queue.pop_front();
               req_valid <= 1'b1;
               if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                  send_gap_left = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: check each taken result, and drive the stall
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transaction with nothing predicted: %h", rsp_data);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               compare_field("trigger_level", want.trigger_level, rsp_data.trigger_level);
               compare_field("busy_res", want.busy_res, rsp_data.busy_res);
               compare_field("done_res", want.done_res, rsp_data.done_res);
               compare_field("nearest_distance", want.nearest_distance,
                             rsp_data.nearest_distance);
               ticks_checked++;
               if (want.done_res) runs_finished++;
            end
         end
         // a long hold-off lets the block fill up and push back on its input
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Abort on a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_tick(input int unsigned start, input int unsigned echo);
      req_type t;
      t.start_req = start[0];
      t.echo_levels = echo[3:0];
      tick_queue.push_back(t);
      ticks_queued++;
   endtask

   // Wait until every queued tick is taken and every result checked.
   task automatic wait_quiet();
      do @(posedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_q.size() != 0);
   endtask

   // Write one register; only call with the block drained.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] reg_value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= reg_value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (reg_index)
         CSR_TRIGGER_US: cfg_trigger = reg_value[7:0];
         CSR_SAMPLES:    cfg_samples = reg_value[3:0];
         CSR_SENSORS:    cfg_sensors = reg_value[2:0];
         CSR_US_PER_CM:  cfg_us_per_cm = reg_value[7:0];
         CSR_GAP_US:     cfg_gap = reg_value;
         default: ;
      endcase
   endtask

   task automatic program_ranging(input int unsigned trig, input int unsigned samples,
                                  input int unsigned sensors, input int unsigned per_cm,
                                  input int unsigned gap);
      write_reg(CSR_TRIGGER_US, CSR_DATA_W'(trig));
      write_reg(CSR_SAMPLES, CSR_DATA_W'(samples));
      write_reg(CSR_SENSORS, CSR_DATA_W'(sensors));
      write_reg(CSR_US_PER_CM, CSR_DATA_W'(per_cm));
      write_reg(CSR_GAP_US, CSR_DATA_W'(gap));
   endtask

   // One well-formed measurement on one sensor, timed against the current
   // settings: trigger ticks, a low wait, a high echo, the fall, the gap.
   // Start is random (or forced high) while the block is busy.
   task automatic queue_echo(input int unsigned sensor, input int unsigned wait_hi,
                             input int unsigned width_lo, input int unsigned width_hi,
                             input bit press);
      int unsigned n_trig;
      int unsigned n_wait;
      int unsigned n_width;
      logic [3:0]  e;
      n_trig = (cfg_trigger == 8'd0) ? 1 : cfg_trigger;
      n_wait = $urandom_range(0, wait_hi);
      n_width = $urandom_range(width_lo, width_hi);
      repeat (n_trig) push_tick(press | $urandom_range(0, 1), $urandom_range(0, 15));
      repeat (n_wait) begin
         e = 4'($urandom_range(0, 15));
         e[sensor] = 1'b0;
         push_tick(press | $urandom_range(0, 1), e);
      end
      repeat (n_width) begin
         e = 4'($urandom_range(0, 15));
         e[sensor] = 1'b1;
         push_tick(press | $urandom_range(0, 1), e);
      end
      e = 4'($urandom_range(0, 15));
      e[sensor] = 1'b0;
      push_tick(press | $urandom_range(0, 1), e);
      repeat (cfg_gap) push_tick(press | $urandom_range(0, 1), $urandom_range(0, 15));
   endtask

   // A whole run: start, then every sample of every sensor in use.
   task automatic queue_run(input int unsigned wait_hi, input int unsigned width_lo,
                            input int unsigned width_hi, input bit press);
      int unsigned s;
      push_tick(1'b1, $urandom_range(0, 15));
      for (s = 0; s < sensors_in_force(); s++) begin
         repeat (samples_in_force()) queue_echo(s, wait_hi, width_lo, width_hi, press);
      end
   endtask

   task automatic queue_noise(input int unsigned count);
      repeat (count) push_tick($urandom_range(0, 3) == 0, $urandom_range(0, 15));
   endtask

   // Drain, then toggle every echo line until the predicted run is over.
   task automatic settle_idle();
      int unsigned i;
      wait_quiet();
      while (m_phase != PH_IDLE) begin
         for (i = 0; i < 16; i++) push_tick(1'b0, (i % 2) ? 4'hF : 4'h0);
         wait_quiet();
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int unsigned random_stop;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Zero trigger, zero samples and sensors, zero divisor, zero gap.
      // Start stays high through the run, the finishing tick included,
      // and the second run starts on the very next tick.
      program_ranging(8'd0, 4'd0, 3'd0, 8'd0, 16'd0);
      queue_run(1, 1, 1, 1'b1);
      queue_run(1, 2, 3, 1'b1);
      settle_idle();

      // More sensors than exist, echo rising without any wait.
      program_ranging(8'd1, 4'd1, 3'd7, 8'd1, 16'd0);
      queue_run(0, 1, 2, 1'b0);
      settle_idle();

      // Lower the sample count in the middle of a run; the open sensor closes early.
      program_ranging(8'd1, 4'd4, 3'd1, 8'd255, 16'd2);
      push_tick(1'b1, 4'h0);
      queue_echo(0, 2, 1, 4, 1'b0);
      queue_echo(0, 2, 1, 4, 1'b0);
      wait_quiet();
      write_reg(CSR_SAMPLES, 16'd1);
      queue_echo(0, 2, 1, 4, 1'b0);
      settle_idle();

      // Random settings, mostly well-formed runs with random content.
      random_stop = ticks_queued + RANDOM_TICKS;
      hold_request = 1'b1;
      while (ticks_queued < random_stop) begin
         // drop idling for the last stretch of the random part
         if (ticks_queued + 300 > random_stop) idle_odds = 0;
         else if ($urandom_range(0, 3) == 0) idle_odds = 0;
         else idle_odds = $urandom_range(2, 10);
         program_ranging(($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                     : $urandom_range(0, 4),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(3, 15)
                                                     : $urandom_range(0, 2),
                         $urandom_range(0, 7),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 8),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20)
                                                     : $urandom_range(0, 3));
         repeat ($urandom_range(2, 6)) begin
            case ($urandom_range(0, 7))
               0: queue_noise($urandom_range(8, 30));
               1: begin
                  // broken run: one measurement, then garbage
                  push_tick(1'b1, $urandom_range(0, 15));
                  queue_echo(0, 6, 1, 12, 1'b0);
                  queue_noise($urandom_range(4, 20));
               end
               default: queue_run(6, 1, 12, 1'b0);
            endcase
            repeat ($urandom_range(0, 3)) push_tick(1'b0, $urandom_range(0, 15));
         end
         settle_idle();
      end

      // Longest trigger pulse, a long echo and a long gap.
      // No idling from here on.
      idle_odds = 0;
      program_ranging(8'd255, 4'd1, 3'd1, 8'd1, 16'd40);
      queue_run(0, 60, 80, 1'b0);
      settle_idle();

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("checked %0d tick results, %0d finished ranging runs", ticks_checked,
               runs_finished);
      $display("%0d register writes, extremes and mid-run changes included", csr_writes);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/urm_pkg.sv
hw/rtl/urm_seq.sv
hw/rtl/ultrasonic_range_min_of_sensors.sv
hw/rtl/urm_checker.sv
dv/testbench.sv
